// ===== rtl/rsrb_pkg.sv =====
// Package for the record sequence reorder buffer: sizes, codes and shared types.
// Used by every module under rtl; depends on nothing.
package rsrb_pkg;

	localparam int SLOT_COUNT      = 16;
	localparam int SLOT_BITS       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int HANDLE_BITS     = 10;
	localparam int OUT_HANDLE_BITS = 10;

	localparam logic [7:0]  TYPE_CCS    = 8'd20;
	localparam logic [15:0] VER_DTLS10  = 16'hFEFF;
	localparam logic [15:0] VER_DTLS12  = 16'hFEFD;
	localparam logic [15:0] VER_DTLS13  = 16'hFEFC;

	localparam logic ACT_INSERT  = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef logic [SLOT_BITS-1:0]       slot_idx_t;
	typedef logic [HANDLE_BITS-1:0]     handle_t;
	typedef logic [OUT_HANDLE_BITS-1:0] out_handle_t;

	typedef enum logic [2:0] {
		ST_RELEASED    = 3'd0,
		ST_EMPTY       = 3'd1,
		ST_NOT_READY   = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_FULL        = 3'd4,
		ST_INSERTED    = 3'd5,
		ST_DUPLICATE   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DRAIN,
		FSM_FINISH
	} fsm_t;

	// one stored descriptor; key is epoch in the upper 16 bits, sequence below
	typedef struct packed {
		logic [63:0] key;
		logic [7:0]  rtype;
		logic [15:0] len;
		handle_t     handle;
	} entry_t;

	typedef struct packed {
		logic        en;
		slot_idx_t   addr;
		entry_t      data;
	} mem_wr_t;

	typedef struct packed {
		logic        action;
		logic [15:0] version;
		logic [7:0]  rtype;
		logic [15:0] epoch;
		logic [47:0] seq;
		logic [15:0] len;
		handle_t     handle;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] epoch;
		logic [47:0] seq;
		logic [7:0]  rtype;
		logic [15:0] len;
		out_handle_t handle;
	} result_t;

	function automatic logic version_ok(input logic [15:0] v);
		return (v == VER_DTLS10) || (v == VER_DTLS12) || (v == VER_DTLS13);
	endfunction

endpackage

// ===== rtl/rsrb_slot_mem.sv =====
// Descriptor store: one write port, one read port with registered read data.
// Depends on rsrb_pkg for the entry type and slot count.
module rsrb_slot_mem (
	input  logic               clk,
	input  rsrb_pkg::mem_wr_t  wr,
	input  rsrb_pkg::slot_idx_t raddr,
	output rsrb_pkg::entry_t   rdata
);

	rsrb_pkg::entry_t mem_q [rsrb_pkg::SLOT_COUNT];
	rsrb_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rsrb_ctrl.sv =====
// Sequencer for the reorder buffer: sweeps the descriptor store for duplicate,
// free slot and smallest key, then commits. Holds valid bits and expected epoch:seq.
// Depends on rsrb_pkg.
module rsrb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  rsrb_pkg::item_t      item,
	output rsrb_pkg::mem_wr_t    mem_wr,
	output rsrb_pkg::slot_idx_t  mem_raddr,
	input  rsrb_pkg::entry_t     mem_rdata,
	output logic                 res_valid,
	output rsrb_pkg::result_t    res,
	input  logic                 res_ready
);

	localparam rsrb_pkg::slot_idx_t LAST_IDX = rsrb_pkg::SLOT_BITS'(rsrb_pkg::SLOT_COUNT - 1);

	rsrb_pkg::fsm_t state_q, state_d;

	// captured transaction
	logic                 act_q;
	logic                 ver_ok_q;
	logic [63:0]          key_q;
	logic [7:0]           rtype_q;
	logic [15:0]          len_q;
	rsrb_pkg::handle_t    hdl_q;

	// sweep pipeline
	rsrb_pkg::slot_idx_t  rd_cnt_q;
	logic                 rd_vld_s1;
	rsrb_pkg::slot_idx_t  rd_idx_s1;

	// sweep results
	logic                 dup_q;
	logic                 free_ok_q;
	rsrb_pkg::slot_idx_t  free_idx_q;
	logic                 min_ok_q;
	rsrb_pkg::slot_idx_t  min_idx_q;
	rsrb_pkg::entry_t     min_q;

	logic [rsrb_pkg::SLOT_COUNT-1:0] valid_q;
	logic [15:0]          exp_epoch_q;
	logic [47:0]          exp_seq_q;

	logic                 accept;
	logic                 commit;
	logic                 do_insert;
	logic                 do_release;
	logic                 slot_v;

	assign accept = req_valid && !req_stall;
	assign commit = res_valid && res_ready;
	assign slot_v = valid_q[rd_idx_s1];
	assign mem_raddr = rd_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsrb_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_stall  = 1'b1;
		res_valid  = 1'b0;
		do_insert  = 1'b0;
		do_release = 1'b0;
		res        = '0;
		res.status = rsrb_pkg::ST_EMPTY;
		case (state_q)
			rsrb_pkg::FSM_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (item.action == rsrb_pkg::ACT_INSERT &&
					    !rsrb_pkg::version_ok(item.version)) begin
						state_d = rsrb_pkg::FSM_FINISH;
					end else begin
						state_d = rsrb_pkg::FSM_SCAN;
					end
				end
			end
			rsrb_pkg::FSM_SCAN: begin
				if (rd_cnt_q == LAST_IDX) begin
					state_d = rsrb_pkg::FSM_DRAIN;
				end
			end
			rsrb_pkg::FSM_DRAIN: begin
				state_d = rsrb_pkg::FSM_FINISH;
			end
			rsrb_pkg::FSM_FINISH: begin
				res_valid = 1'b1;
				if (act_q == rsrb_pkg::ACT_INSERT) begin
					if (!ver_ok_q) begin
						res.status = rsrb_pkg::ST_BAD_VERSION;
					end else if (dup_q) begin
						res.status = rsrb_pkg::ST_DUPLICATE;
					end else if (!free_ok_q) begin
						res.status = rsrb_pkg::ST_FULL;
					end else begin
						res.status = rsrb_pkg::ST_INSERTED;
						do_insert  = 1'b1;
					end
				end else begin
					if (!min_ok_q) begin
						res.status = rsrb_pkg::ST_EMPTY;
					end else if (min_q.key != {exp_epoch_q, exp_seq_q}) begin
						res.status = rsrb_pkg::ST_NOT_READY;
					end else begin
						res.status = rsrb_pkg::ST_RELEASED;
						res.epoch  = min_q.key[63:48];
						res.seq    = min_q.key[47:0];
						res.rtype  = min_q.rtype;
						res.len    = min_q.len;
						res.handle = rsrb_pkg::out_handle_t'(min_q.handle);
						do_release = 1'b1;
					end
				end
				if (res_ready) begin
					state_d = rsrb_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = rsrb_pkg::FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_wr            = '0;
		mem_wr.en         = commit && do_insert;
		mem_wr.addr       = free_idx_q;
		mem_wr.data.key   = key_q;
		mem_wr.data.rtype = rtype_q;
		mem_wr.data.len   = len_q;
		mem_wr.data.handle = hdl_q;
	end

	// latch the transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= item.action;
			ver_ok_q <= rsrb_pkg::version_ok(item.version);
			key_q    <= {item.epoch, item.seq};
			rtype_q  <= item.rtype;
			len_q    <= item.len;
			hdl_q    <= item.handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_vld_s1 <= (state_q == rsrb_pkg::FSM_SCAN);
			rd_idx_s1 <= rd_cnt_q;
			if (accept) begin
				rd_cnt_q <= '0;
			end else if (state_q == rsrb_pkg::FSM_SCAN) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	// fold each returned entry into the sweep results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q     <= 1'b0;
			free_ok_q <= 1'b0;
			min_ok_q  <= 1'b0;
		end else if (accept) begin
			dup_q     <= 1'b0;
			free_ok_q <= 1'b0;
			min_ok_q  <= 1'b0;
		end else if (rd_vld_s1) begin
			if (slot_v && mem_rdata.key == key_q) begin
				dup_q <= 1'b1;
			end
			if (!slot_v && !free_ok_q) begin
				free_ok_q <= 1'b1;
			end
			if (slot_v && (!min_ok_q || mem_rdata.key < min_q.key)) begin
				min_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (!slot_v && !free_ok_q) begin
				free_idx_q <= rd_idx_s1;
			end
			if (slot_v && (!min_ok_q || mem_rdata.key < min_q.key)) begin
				min_idx_q <= rd_idx_s1;
				min_q     <= mem_rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			exp_epoch_q <= '0;
			exp_seq_q   <= '0;
		end else if (commit) begin
			if (do_insert) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (do_release) begin
				valid_q[min_idx_q] <= 1'b0;
				if (min_q.rtype == rsrb_pkg::TYPE_CCS) begin
					exp_epoch_q <= exp_epoch_q + 16'd1;
					exp_seq_q   <= '0;
				end else begin
					exp_epoch_q <= min_q.key[63:48];
					exp_seq_q   <= min_q.key[47:0] + 48'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/record_sequence_reorder_buffer.sv =====
// Top level of the record sequence reorder buffer: request port, sequencer,
// descriptor store and the response output register. Depends on rsrb_pkg,
// rsrb_slot_mem and rsrb_ctrl.
//
//  - Request channel (req_valid/req_stall): one transaction per record. action 0
//    inserts a descriptor under key epoch:seq; action 1 asks for the next
//    in-order record. A transaction is taken when req_valid is high and
//    req_stall is low.
//  - Response channel (rsp_valid/rsp_stall): exactly one response per request,
//    in request order; the record fields are only nonzero on a release.
//  - Sweep: a request with a good version or a release sweeps all SLOT_COUNT
//    slots through the single read port of the descriptor store and occupies
//    the block until its response is loaded into the output register; no new
//    request is taken in that time. An insert with a bad version skips the
//    sweep and goes straight to its response.
//  - The output register holds one response while the next request is worked on;
//    if the receiver keeps stalling, the following response holds in the
//    sequencer and the request side stalls.
//  - Reset (arst_n low) empties the store, whose valid bits are flip-flops, and
//    clears expected epoch and sequence; no clearing pass is needed.
module record_sequence_reorder_buffer (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        req_valid,
	output logic        req_stall,
	input  logic        action,
	input  logic [15:0] record_version,
	input  logic [7:0]  record_type,
	input  logic [15:0] record_epoch,
	input  logic [47:0] record_seq,
	input  logic [15:0] record_length,
	input  logic [9:0]  record_handle,

	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [15:0] out_epoch,
	output logic [47:0] out_seq,
	output logic [7:0]  out_type,
	output logic [15:0] out_length,
	output logic [9:0]  out_handle
);

	rsrb_pkg::item_t     item;
	rsrb_pkg::mem_wr_t   mem_wr;
	rsrb_pkg::slot_idx_t mem_raddr;
	rsrb_pkg::entry_t    mem_rdata;
	rsrb_pkg::result_t   res;
	logic                res_valid;
	logic                res_ready;

	// response output register
	logic                out_valid_q;
	rsrb_pkg::result_t   out_q;

	// bundle the request fields; the handle is cut or widened to the stored width
	always_comb begin
		item.action  = action;
		item.version = record_version;
		item.rtype   = record_type;
		item.epoch   = record_epoch;
		item.seq     = record_seq;
		item.len     = record_length;
		item.handle  = rsrb_pkg::handle_t'(record_handle);
	end

	rsrb_slot_mem u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rsrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.item      (item),
		.mem_wr    (mem_wr),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// load a new response when the register is empty or being drained this cycle
	assign res_ready = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// hold the payload while stalled
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign status     = out_q.status;
	assign out_epoch  = out_q.epoch;
	assign out_seq    = out_q.seq;
	assign out_type   = out_q.rtype;
	assign out_length = out_q.len;
	assign out_handle = out_q.handle;

endmodule
